>>> hdl/tno_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Telnet option negotiator package
// Telnet command codes, terminal control characters and parser phase codes.
// ----------------------------------------------------------------------------
package tno_pkg;

   localparam logic [7:0] TN_IAC  = 8'd255;
   localparam logic [7:0] TN_DONT = 8'd254;
   localparam logic [7:0] TN_DO   = 8'd253;
   localparam logic [7:0] TN_WONT = 8'd252;
   localparam logic [7:0] TN_WILL = 8'd251;
   localparam logic [7:0] TN_ECHO = 8'd1;
   localparam logic [7:0] CH_CR   = 8'd13;
   localparam logic [7:0] CH_LF   = 8'd10;

   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_AFTER  = 2'd1;
   localparam logic [1:0] PH_OPTION = 2'd2;

   localparam int unsigned MAX_RES = 3;

   typedef logic [7:0] byte_type;
   typedef logic [1:0] count_type;

endpackage
`default_nettype wire

>>> hdl/telnet_option_negotiator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Telnet option negotiator
// Parses received telnet bytes, answers option commands and forwards data.
// ----------------------------------------------------------------------------
// Usage: received bytes enter on the req_ channel, one byte per item. Each
// byte causes zero to three items on the rsp_ channel: data bytes for the
// terminal (rsp_to_server low) or a three-byte negotiation reply for the
// server (rsp_to_server high). The final item caused by a byte has rsp_last
// high. The csr_ channel writes the session-open bit and is always ready.
// A byte is decoded in the cycle it is accepted and its first result item is
// presented in the next cycle. While the receiver is ready, a new byte can be
// accepted every cycle as long as each byte causes at most one item; a CR
// causes two items and a reply three, which the single output port drains
// from the result buffer one item per cycle while the receiver is ready. The
// next byte is accepted in the cycle the last pending result item is taken.
// Reset clears the parser, the echo state, the session-open bit and the
// result item count. When the receiver stalls, the buffer holds its items and
// req_ready falls until only the last pending item remains and is taken.
// Bytes accepted while the session is closed are consumed with no effect.
module telnet_option_negotiator_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_session_open,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_in_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_to_server,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last
);
   import tno_pkg::*;

   logic                         open_ff;
   logic [1:0]                   phase_ff, phase_in;
   byte_type                     verb_ff, verb_in;
   logic                         echo_ff, echo_in;
   count_type                    cnt_ff, cnt_in;
   logic                         srv_ff, srv_in;
   byte_type [MAX_RES-1:0]       buf_ff, buf_in;

   count_type                    res_cnt;
   logic                         res_srv;
   byte_type [MAX_RES-1:0]       res_buf;
   logic [1:0]                   dec_phase;
   byte_type                     dec_verb;
   logic                         dec_echo;
   byte_type                     reply_verb;
   logic                         reply_ok;
   logic                         accept, pop, work;

   assign csr_ready     = 1'b1;
   assign rsp_valid     = (cnt_ff != 2'd0);
   assign rsp_last      = (cnt_ff == 2'd1);
   assign rsp_to_server = srv_ff;
   assign rsp_out_byte  = buf_ff[0];
   assign req_ready     = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_ready);
   assign accept        = req_valid && req_ready;
   assign pop           = rsp_valid && rsp_ready;
   assign work          = accept && open_ff;

   always_comb begin
      reply_ok   = 1'b0;
      reply_verb = TN_WONT;
      dec_echo   = echo_ff;
      if (verb_ff == TN_WILL) begin
         if (req_in_byte == TN_ECHO) begin
            reply_ok   = !echo_ff;
            reply_verb = TN_DO;
            dec_echo   = 1'b1;
         end else begin
            reply_ok   = 1'b1;
            reply_verb = TN_DONT;
         end
      end else if (verb_ff == TN_WONT) begin
         if (req_in_byte == TN_ECHO) begin
            reply_ok   = echo_ff;
            reply_verb = TN_DONT;
            dec_echo   = 1'b0;
         end else begin
            reply_ok   = 1'b1;
            reply_verb = TN_DONT;
         end
      end else if (verb_ff inside {TN_DO, TN_DONT}) begin
         reply_ok   = 1'b1;
         reply_verb = TN_WONT;
      end
   end

   always_comb begin
      dec_phase = PH_IDLE;
      dec_verb  = verb_ff;
      res_cnt   = 2'd0;
      res_srv   = 1'b0;
      res_buf   = '0;
      case (phase_ff)
         PH_AFTER: begin
            if (req_in_byte == TN_IAC) begin
               res_cnt    = 2'd1;
               res_buf[0] = TN_IAC;
            end else begin
               dec_verb  = req_in_byte;
               dec_phase = PH_OPTION;
            end
         end
         PH_OPTION: begin
            res_srv = 1'b1;
            if (reply_ok) begin
               res_cnt    = 2'd3;
               res_buf[0] = TN_IAC;
               res_buf[1] = reply_verb;
               res_buf[2] = req_in_byte;
            end
         end
         default: begin
            if (req_in_byte == TN_IAC) begin
               dec_phase = PH_AFTER;
            end else if (req_in_byte == CH_CR) begin
               res_cnt    = 2'd2;
               res_buf[0] = CH_CR;
               res_buf[1] = CH_LF;
            end else if (req_in_byte != CH_LF) begin
               res_cnt    = 2'd1;
               res_buf[0] = req_in_byte;
            end
         end
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      verb_in  = verb_ff;
      echo_in  = echo_ff;
      cnt_in   = cnt_ff;
      srv_in   = srv_ff;
      buf_in   = buf_ff;
      if (pop) begin
         cnt_in    = cnt_ff - 2'd1;
         buf_in[0] = buf_ff[1];
         buf_in[1] = buf_ff[2];
      end
      if (work) begin
         phase_in = dec_phase;
         verb_in  = dec_verb;
         if (phase_ff == PH_OPTION) begin
            echo_in = dec_echo;
         end
         if (res_cnt != 2'd0) begin
            cnt_in = res_cnt;
            srv_in = res_srv;
            buf_in = res_buf;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff  <= 1'b0;
         phase_ff <= PH_IDLE;
         verb_ff  <= '0;
         echo_ff  <= 1'b0;
         cnt_ff   <= 2'd0;
      end else begin
         if (csr_valid && csr_ready) begin
            open_ff <= csr_session_open;
         end
         phase_ff <= phase_in;
         verb_ff  <= verb_in;
         echo_ff  <= echo_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      srv_ff <= srv_in;
      buf_ff <= buf_in;
   end

endmodule
`default_nettype wire

>>> hdl/tno_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Telnet option negotiator checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module tno_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_to_server,
   input wire logic [7:0]  rsp_out_byte,
   input wire logic        rsp_last
);
   import tno_pkg::*;

   // A stalled result item keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_to_server) && $stable(rsp_last))
      else $error("result item changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item present right after reset");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("byte accepted with several result items pending");

   a_continue: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid
         && (rsp_to_server == $past(rsp_to_server)))
      else $error("multi-item result broken off");

   a_only_cr_splits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last && !rsp_to_server |-> rsp_out_byte == CH_CR)
      else $error("data item other than CR followed by another item");

endmodule

bind telnet_option_negotiator_unit tno_checker u_tno_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_to_server (rsp_to_server),
   .rsp_out_byte  (rsp_out_byte),
   .rsp_last      (rsp_last)
);
`default_nettype wire
